// File: hdl/cursor_sequence_store_core_assert.svh
// Assertion macros for the cursor sequence store.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Plain implication checked on every clock edge outside reset.
`define CSS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSS_ASSERT(label, ante, cons, msg)
`define CSS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/css_pkg.sv
// Shared types and constants of the cursor sequence store.
// No dependencies; used by every module of the block.
package css_pkg;

  localparam int unsigned CAPACITY_DEF    = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned REQ_W           = 3;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned COUNT_OUT_W     = 6;

  // Request codes; the remaining codes leave the store unchanged.
  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 3'd0,
    REQ_ADVANCE = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_ATTACH  = 3'd3,
    REQ_REMOVE  = 3'd4
  } css_req_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } css_state_e;

  // Status handed from the sequencer to the top level.
  typedef struct packed {
    logic ready;
    logic done;
    logic has_current;
    logic rejected;
  } css_status_t;

endpackage

// File: hdl/css_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on css_pkg for its default sizes.
module css_ram #(
  parameter int unsigned WIDTH = css_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned DEPTH = css_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/css_ctrl.sv
// Sequencer of the cursor sequence store: count, cursor and the shared shift unit.
// Depends on css_pkg; drives the ports of one css_ram instance.
module css_ctrl #(
  parameter int unsigned CAPACITY    = css_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned CW          = $clog2(CAPACITY + 1),
  parameter int unsigned AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [css_pkg::REQ_W-1:0]   req_type_i,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  input  logic                        out_free_i,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [VALUE_WIDTH-1:0]      ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [VALUE_WIDTH-1:0]      ram_rdata_i,
  output logic [CW-1:0]               count_o,
  output css_pkg::css_status_t        status_o
);

  import css_pkg::*;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  css_state_e             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          cursor_q, cursor_d;
  logic [CW-1:0]          src_q, src_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          dst_q, dst_d;
  logic                   more_q, more_d;
  logic                   pend_q, pend_d;
  logic                   down_q, down_d;
  logic                   place_q, place_d;
  logic                   rej_q, rej_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;

  logic          has_cur;
  logic          full;
  logic [CW-1:0] cursor_inc;
  logic [CW-1:0] src_inc;
  logic [CW-1:0] src_dec;
  logic [CW-1:0] place_pos;

  assign has_cur    = cursor_q < count_q;
  assign full       = count_q >= CAP_C;
  assign cursor_inc = cursor_q + 1'b1;
  assign src_inc    = src_q + 1'b1;
  assign src_dec    = src_q - 1'b1;

  // Control state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      more_q   <= 1'b0;
      pend_q   <= 1'b0;
      rej_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      more_q   <= more_d;
      pend_q   <= pend_d;
      rej_q    <= rej_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    pos_q   <= pos_d;
    dst_q   <= dst_d;
    down_q  <= down_d;
    place_q <= place_d;
    val_q   <= val_d;
  end

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    src_d       = src_q;
    pos_d       = pos_q;
    dst_d       = dst_q;
    more_d      = more_q;
    pend_d      = pend_q;
    down_d      = down_q;
    place_d     = place_q;
    rej_d       = rej_q;
    val_d       = val_q;
    place_pos   = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = dst_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = src_q[AW-1:0];
    status_o    = '{ready: 1'b0, done: 1'b0, has_current: has_cur, rejected: rej_q};

    unique case (state_q)
      ST_IDLE: begin
        status_o.ready = 1'b1;
        if (start_i) begin
          rej_d   = 1'b0;
          pend_d  = 1'b0;
          more_d  = 1'b0;
          val_d   = value_i;
          state_d = ST_READ;
          unique case (req_type_i) inside
            REQ_START: begin
              cursor_d = '0;
            end
            REQ_ADVANCE: begin
              if (has_cur) begin
                cursor_d = cursor_inc;
              end
            end
            REQ_INSERT, REQ_ATTACH: begin
              if (full) begin
                rej_d = 1'b1;
              end else begin
                if (req_type_i == REQ_INSERT) begin
                  place_pos = has_cur ? cursor_q : '0;
                end else begin
                  place_pos = has_cur ? cursor_inc : count_q;
                end
                // Move entries pos..count-1 up by one, highest first.
                pos_d   = place_pos;
                src_d   = count_q - 1'b1;
                more_d  = count_q > place_pos;
                down_d  = 1'b1;
                place_d = 1'b1;
                state_d = ST_SHIFT;
              end
            end
            REQ_REMOVE: begin
              if (has_cur) begin
                // Move entries cursor+1..count-1 down by one, lowest first.
                src_d   = cursor_inc;
                more_d  = cursor_inc < count_q;
                down_d  = 1'b0;
                place_d = 1'b0;
                state_d = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // One entry read per cycle; its data is written in the next cycle.
      ST_SHIFT: begin
        ram_we_o = pend_q;
        ram_re_o = more_q;
        if (more_q) begin
          pend_d = 1'b1;
          if (down_q) begin
            dst_d  = src_inc[AW-1:0];
            src_d  = src_dec;
            more_d = src_q != pos_q;
          end else begin
            dst_d  = src_dec[AW-1:0];
            src_d  = src_inc;
            more_d = src_inc < count_q;
          end
        end else begin
          pend_d  = 1'b0;
          state_d = ST_WRITE;
        end
      end

      // Place the new value, or shrink the store after a removal.
      ST_WRITE: begin
        if (place_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_q[AW-1:0];
          ram_wdata_o = val_q;
          count_d     = count_q + 1'b1;
          cursor_d    = pos_q;
        end else begin
          count_d = count_q - 1'b1;
        end
        state_d = ST_READ;
      end

      // Fetch the item under the cursor for the result.
      ST_READ: begin
        ram_re_o    = has_cur;
        ram_raddr_o = cursor_q[AW-1:0];
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        status_o.done = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign count_o = count_q;

endmodule

// File: hdl/cursor_sequence_store_core.sv
// Cursor sequence store: ordered store of CAPACITY words with a cursor.
// Start, advance, unused codes, refusals, removes with no current item: READ, then DONE.
// Insert, attach, remove: SHIFT, WRITE, READ, DONE; SHIFT moves n entries (at most CAPACITY - 1),
// one entry per cycle through the single memory port pair.
// One request at a time; the next is taken once the result sits in the output register.
// Reset (rst_ni, asynchronous, active low) empties the store and moves the cursor to the front.
`include "cursor_sequence_store_core_assert.svh"

module cursor_sequence_store_core #(
  parameter int unsigned CAPACITY    = css_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [css_pkg::REQ_W-1:0]         req_type_i,
  input  logic [css_pkg::DATA_W-1:0]        entry_value_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [css_pkg::DATA_W-1:0]        current_value_o,
  output logic                              has_current_o,
  output logic [css_pkg::COUNT_OUT_W-1:0]   item_count_o,
  output logic                              rejected_o
);

  import css_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   accept;
  logic                   out_free;
  logic                   load;
  logic [VALUE_WIDTH-1:0] value_in;
  logic [VALUE_WIDTH+DATA_W-1:0]  value_in_ext;
  logic [VALUE_WIDTH+DATA_W-1:0]  value_out_ext;
  logic [CW+COUNT_OUT_W-1:0]      count_ext;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [CW-1:0]          count;
  css_status_t            status;

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      cur_value_q;
  logic                   has_cur_q;
  logic [COUNT_OUT_W-1:0] count_out_q;
  logic                   rej_q;

  assign in_ready = status.ready;
  assign accept   = in_valid && status.ready;
  assign out_free = !out_valid_q || out_ready;
  assign load     = status.done && out_free;

  // Fit the request value to the stored width and the stored word to the result width.
  assign value_in_ext  = {{VALUE_WIDTH{1'b0}}, entry_value_i};
  assign value_in      = value_in_ext[VALUE_WIDTH-1:0];
  assign value_out_ext = {{DATA_W{1'b0}}, ram_rdata};
  assign count_ext     = {{COUNT_OUT_W{1'b0}}, count};

  css_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .CW         (CW),
    .AW         (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .req_type_i (req_type_i),
    .value_i    (value_in),
    .out_free_i (out_free),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .count_o    (count),
    .status_o   (status)
  );

  css_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, captured when the sequencer finishes a request.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_value_q <= status.has_current ? value_out_ext[DATA_W-1:0] : '0;
      has_cur_q   <= status.has_current;
      count_out_q <= count_ext[COUNT_OUT_W-1:0];
      rej_q       <= status.rejected;
    end
  end

  assign out_valid       = out_valid_q;
  assign current_value_o = cur_value_q;
  assign has_current_o   = has_cur_q;
  assign item_count_o    = count_out_q;
  assign rejected_o      = rej_q;

  // The block is busy in the cycle after it takes a request.
  `CSS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready right after a request")
  // A refused insert or attach only happens on a full store.
  `CSS_ASSERT(a_rej_full, load && status.rejected, count == CW'(CAPACITY), "refused while not full")
  // The count never exceeds the capacity.
  `CSS_ASSERT(a_count_bound, 1'b1, count <= CW'(CAPACITY), "item count above capacity")

endmodule
